// File: src/iirq24_pkg.sv
// ----------------------------------------------------------------------------
// iirq24_pkg
// Shared widths, register indexes, types and helpers of the Direct Form II
// IIR filter with Q8.24 coefficients.
// ----------------------------------------------------------------------------
package iirq24_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int COEF_FRAC = 24;
	localparam int MAX_TAPS  = 4;
	localparam int TAPS_W    = 3;
	localparam int CFG_IDX_W = 4;
	localparam int STEP_W    = 3;
	localparam int KIDX_W    = 2;
	localparam int PROD_W    = 2 * SAMPLE_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [TAPS_W-1:0]          taps_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [KIDX_W-1:0]          kidx_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_FEED_0     = 4'd0;
	localparam cfg_idx_t REG_FEED_1     = 4'd1;
	localparam cfg_idx_t REG_FEED_2     = 4'd2;
	localparam cfg_idx_t REG_FEED_3     = 4'd3;
	localparam cfg_idx_t REG_FEEDBACK_1 = 4'd4;
	localparam cfg_idx_t REG_FEEDBACK_2 = 4'd5;
	localparam cfg_idx_t REG_FEEDBACK_3 = 4'd6;
	localparam cfg_idx_t REG_TAPS       = 4'd7;

	localparam taps_t TAPS_RESET = taps_t'(MAX_TAPS);

	// Tag that travels with each product through the multiplier stage.
	typedef struct packed {
		logic valid;
		logic to_s;
		logic last;
	} mtag_t;

	// Tap count actually used: zero acts as one, large values saturate.
	function automatic taps_t eff_taps(input taps_t t);
		taps_t n;
		n = t;
		if (n == '0) begin
			n = taps_t'(1);
		end else if (n > taps_t'(MAX_TAPS)) begin
			n = taps_t'(MAX_TAPS);
		end
		return n;
	endfunction

endpackage

// File: src/iirq24_ifs.sv
// ----------------------------------------------------------------------------
// iirq24 interfaces
// Sample input, sample output and configuration write channels.
// ----------------------------------------------------------------------------
interface iirq24_in_if
	import iirq24_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirq24_out_if
	import iirq24_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface iirq24_cfg_if
	import iirq24_pkg::*;
();
	logic                valid;
	logic                ready;
	cfg_idx_t            index;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/iir_direct_form2_q24_core.sv
// ----------------------------------------------------------------------------
// iir_direct_form2_q24_core
// Direct Form II IIR filter, signed 32-bit samples, Q8.24 coefficients.
// ----------------------------------------------------------------------------
// One sample in gives one sample out. A single 32x32 multiplier is shared by
// all taps: with N taps in use an item issues 2N-1 products, one per cycle,
// and the result is formed in the wait state once the last product lands.
// The result sits in an output register, so it may wait for the sink while
// the next sample is taken. Coefficients and the tap count are written over
// the configuration channel; the user must write them only while the filter
// is idle, which the block itself does not enforce. Register indexes above 7
// are ignored.
// ----------------------------------------------------------------------------
module iir_direct_form2_q24_core
	import iirq24_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	iirq24_in_if.sink    in_ch,
	iirq24_out_if.source out_ch,
	iirq24_cfg_if.sink   cfg
);

	iirq24_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

endmodule

// File: src/iirq24_mult.sv
// ----------------------------------------------------------------------------
// iirq24_mult
// Shared Q8.24 multiplier: signed 32x32 product, arithmetic shift right by
// the fraction width, truncated to 32 bits, registered with its tag.
// ----------------------------------------------------------------------------
module iirq24_mult
	import iirq24_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  sample_t op_coef,
	input  sample_t op_data,
	input  mtag_t   tag,
	output sample_t prod,
	output mtag_t   prod_tag
);

	logic signed [PROD_W-1:0] full;
	sample_t                  prod_s1;
	mtag_t                    tag_s1;

	assign full = op_coef * op_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= full[COEF_FRAC+SAMPLE_W-1:COEF_FRAC];
	end

	assign prod     = prod_s1;
	assign prod_tag = tag_s1;

endmodule

// File: src/iirq24_seq.sv
// ----------------------------------------------------------------------------
// iirq24_seq
// Sequencer and accumulators: steps the shared multiplier through the
// feedback taps, the feedforward taps and finally b0 times s.
// ----------------------------------------------------------------------------
module iirq24_seq
	import iirq24_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	iirq24_in_if.sink    in_ch,
	iirq24_out_if.source out_ch,
	iirq24_cfg_if.sink   cfg
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_HOLD
	} state_t;

	state_t  state_q;
	taps_t   taps_q;
	taps_t   n_q;
	step_t   step_q;
	sample_t s_q;
	sample_t y_q;
	sample_t out_q;
	logic    out_valid_q;

	sample_t ff_q [MAX_TAPS];
	sample_t fb_q [1:MAX_TAPS-1];
	sample_t dl_q [1:MAX_TAPS-1];

	sample_t op_coef;
	sample_t op_data;
	mtag_t   tag;
	sample_t prod;
	mtag_t   prod_tag;
	step_t   nm1;
	step_t   last_step;
	kidx_t   k_fb;
	kidx_t   k_ff;
	sample_t y_fin;
	logic    out_free;

	assign nm1       = step_t'(n_q) - step_t'(1);
	assign last_step = step_t'({n_q, 1'b0} - 4'd2);
	assign k_fb      = kidx_t'(step_q + step_t'(1));
	assign k_ff      = kidx_t'(step_q - nm1 + step_t'(1));

	// Operand selection for the shared multiplier.
	always_comb begin
		tag       = '0;
		tag.valid = (state_q == ST_RUN);
		tag.last  = (step_q == last_step);
		tag.to_s  = 1'b0;
		priority if (step_q < nm1) begin
			op_coef  = sample_t'(0) - fb_q[k_fb];
			op_data  = dl_q[k_fb];
			tag.to_s = 1'b1;
		end else if (step_q < last_step) begin
			op_coef = ff_q[k_ff];
			op_data = dl_q[k_ff];
		end else begin
			op_coef = ff_q[0];
			op_data = s_q;
		end
	end

	iirq24_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_coef  (op_coef),
		.op_data  (op_data),
		.tag      (tag),
		.prod     (prod),
		.prod_tag (prod_tag)
	);

	assign y_fin    = y_q + prod;
	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;
	assign cfg.ready         = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taps_q      <= TAPS_RESET;
			n_q         <= TAPS_RESET;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TAPS; i++) begin
				ff_q[i] <= '0;
			end
			for (int i = 1; i < MAX_TAPS; i++) begin
				fb_q[i] <= '0;
				dl_q[i] <= '0;
			end
		end else begin
			// In the wait and hold states the case below decides the output flag.
			if (out_valid_q && out_ch.ready && state_q != ST_WAIT && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FEED_0:     ff_q[0] <= cfg.data;
					REG_FEED_1:     ff_q[1] <= cfg.data;
					REG_FEED_2:     ff_q[2] <= cfg.data;
					REG_FEED_3:     ff_q[3] <= cfg.data;
					REG_FEEDBACK_1: fb_q[1] <= cfg.data;
					REG_FEEDBACK_2: fb_q[2] <= cfg.data;
					REG_FEEDBACK_3: fb_q[3] <= cfg.data;
					REG_TAPS:       taps_q  <= cfg.data[TAPS_W-1:0];
					default: ;
				endcase
			end

			// Products land in the cycle after issue; all but the last go into s or y.
			if (prod_tag.valid && !prod_tag.last) begin
				if (prod_tag.to_s) begin
					s_q <= s_q + prod;
				end else begin
					y_q <= y_q + prod;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						s_q     <= in_ch.sample_in;
						y_q     <= '0;
						n_q     <= eff_taps(taps_q);
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + step_t'(1);
					if (step_q == last_step) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// The last product is b0 times s; s is final by now.
					for (int k = 2; k < MAX_TAPS; k++) begin
						if (taps_t'(k) < n_q) begin
							dl_q[k] <= dl_q[k-1];
						end
					end
					if (n_q >= taps_t'(2)) begin
						dl_q[1] <= s_q;
					end
					if (out_free) begin
						out_q       <= y_fin;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						y_q     <= y_fin;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_q       <= y_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The final product arrives exactly when the sequencer waits for it.
	a_last_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(prod_tag.valid && prod_tag.last) |-> (state_q == ST_WAIT))
		else $error("final product outside of wait state");

	// Every wait cycle consumes the final product.
	a_wait_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (prod_tag.valid && prod_tag.last))
		else $error("wait state without final product");

	// Feedback products only come while the b0 product is not yet issued.
	a_fb_before_last: assert property (@(posedge clk) disable iff (!arst_n)
		(prod_tag.valid && prod_tag.to_s) |-> (state_q == ST_RUN))
		else $error("feedback product after sequence end");

	// The tap count in use stays in range during a run.
	a_taps_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (n_q >= taps_t'(1) && n_q <= taps_t'(MAX_TAPS)))
		else $error("tap count out of range");

endmodule

// File: sim/tb_iir_direct_form2_q24_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iir_direct_form2_q24_core
// Self-checking bench for the Direct Form II IIR filter with Q8.24
// coefficients. Every accepted sample is run through a behavioral copy of the
// filter, and every output beat is compared in order against it. A directed
// pass covers the field and coefficient extremes and the tap count corner
// cases. Random phases then follow, each with fresh coefficients and with
// sender gaps and sink stalls each switched on at random.
// ----------------------------------------------------------------------------

class filter_scoreboard;
	logic [31:0] feed_coef [4];
	logic [31:0] back_coef [4];
	logic [2:0]  taps;
	logic [31:0] delay_line [4];
	logic [31:0] pending_outputs [$];
	int unsigned mismatches;
	int unsigned compared;

	function new();
		for (int k = 0; k < 4; k++) begin
			feed_coef[k]  = '0;
			back_coef[k]  = '0;
			delay_line[k] = '0;
		end
		taps       = 3'd4;
		mismatches = 0;
		compared   = 0;
	endfunction

	// Q8.24 product: full signed 64-bit product, shifted by 24, low 32 bits.
	function logic [31:0] q24_mul(logic [31:0] c, logic [31:0] v);
		logic signed [63:0] p;
		p = $signed({{32{c[31]}}, c}) * $signed({{32{v[31]}}, v});
		return p[55:24];
	endfunction

	function void note_write(iirq24_pkg::cfg_idx_t idx, logic [31:0] data);
		case (idx)
			iirq24_pkg::REG_FEED_0:     feed_coef[0] = data;
			iirq24_pkg::REG_FEED_1:     feed_coef[1] = data;
			iirq24_pkg::REG_FEED_2:     feed_coef[2] = data;
			iirq24_pkg::REG_FEED_3:     feed_coef[3] = data;
			iirq24_pkg::REG_FEEDBACK_1: back_coef[1] = data;
			iirq24_pkg::REG_FEEDBACK_2: back_coef[2] = data;
			iirq24_pkg::REG_FEEDBACK_3: back_coef[3] = data;
			iirq24_pkg::REG_TAPS:       taps = data[2:0];
			default: ;
		endcase
	endfunction

	function void note_sample(logic [31:0] x);
		int          n;
		logic [31:0] s;
		logic [31:0] y;
		logic [31:0] neg_a;
		n = int'(taps);
		if (n == 0) begin
			n = 1;
		end else if (n > 4) begin
			n = 4;
		end
		s = x;
		y = '0;
		for (int k = 1; k < n; k++) begin
			neg_a = -back_coef[k];
			s = s + q24_mul(neg_a, delay_line[k]);
			y = y + q24_mul(feed_coef[k], delay_line[k]);
		end
		y = y + q24_mul(feed_coef[0], s);
		for (int k = n - 1; k >= 2; k--) begin
			delay_line[k] = delay_line[k - 1];
		end
		if (n >= 2) begin
			delay_line[1] = s;
		end
		pending_outputs.push_back(y);
	endfunction

	function void check_output(logic [31:0] y);
		logic [31:0] want;
		if (pending_outputs.size() == 0) begin
			$display("%0t: output %h arrived with no sample outstanding", $time, y);
			mismatches++;
		end else begin
			want = pending_outputs.pop_front();
			compared++;
			if (want !== y) begin
				$display("%0t: sample_out mismatch: expected %h actual %h", $time, want, y);
				mismatches++;
			end
		end
	endfunction
endclass

module tb_iir_direct_form2_q24_core;
	import iirq24_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RAND_PHASES  = 10;
	localparam int unsigned PHASE_ITEMS  = 100;
	localparam int unsigned SETTLE_LIMIT = 12;
	localparam cfg_idx_t    REG_SPARE_LO = 4'd8;
	localparam cfg_idx_t    REG_SPARE_HI = 4'd15;

	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0100_0000;
	localparam logic [31:0] Q_NEG1 = 32'hFF00_0000;

	logic clk;
	logic arst_n;

	iirq24_in_if  in_if ();
	iirq24_out_if out_if ();
	iirq24_cfg_if cfg_if ();

	iir_direct_form2_q24_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg    (cfg_if)
	);

	filter_scoreboard sb;

	int unsigned cycles;
	int unsigned samples_sent;
	int unsigned reg_writes;
	int unsigned settings_used;
	bit          in_gaps_on;
	bit          out_stalls_on;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Output sink: while stalls are on, ready drops for a random number of cycles, possibly none, before each beat.
	initial begin
		int unsigned stall;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = out_stalls_on ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				@(negedge clk);
				out_if.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_if.ready = 1'b1;
			do @(posedge clk); while (!out_if.valid);
		end
	end

	always @(posedge clk) begin
		if (out_if.valid && out_if.ready) begin
			sb.check_output(out_if.sample_out);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.note_write(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic send_sample(logic [31:0] x);
		int unsigned gap;
		gap = in_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_if.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_if.valid     = 1'b1;
		in_if.sample_in = x;
		do @(posedge clk); while (!in_if.ready);
		sb.note_sample(x);
		samples_sent++;
	endtask

	// Hold the sender off until every outstanding output has been taken.
	task automatic drain_filter();
		@(negedge clk);
		in_if.valid = 1'b0;
		while (sb.pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_LIMIT) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return '1;
			4: return Q_ONE;
			default: return Q_NEG1;
		endcase
	endfunction

	function automatic logic [31:0] pick_sample(int unsigned style);
		case (style)
			0: return $urandom();
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return ($urandom_range(0, 3) == 0) ? pick_extreme() : $urandom();
		endcase
	endfunction

	// Coefficients are either tame (magnitude under 0.4), anything at all,
	// or mostly the corner values.
	function automatic logic [31:0] pick_coef(int unsigned style);
		case (style)
			0: return $urandom_range(0, 32'h00CC_CCCC) - 32'h0066_6666;
			1: return $urandom();
			default: return ($urandom_range(0, 1) == 0) ? pick_extreme() : $urandom();
		endcase
	endfunction

	task automatic load_filter(logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
	                           logic [31:0] b3, logic [31:0] a1, logic [31:0] a2,
	                           logic [31:0] a3, logic [2:0] n);
		write_reg(REG_FEED_0, b0);
		write_reg(REG_FEED_1, b1);
		write_reg(REG_FEED_2, b2);
		write_reg(REG_FEED_3, b3);
		write_reg(REG_FEEDBACK_1, a1);
		write_reg(REG_FEEDBACK_2, a2);
		write_reg(REG_FEEDBACK_3, a3);
		write_reg(REG_TAPS, {29'd0, n});
		settings_used++;
	endtask

	initial begin
		int unsigned coef_style;
		int unsigned sample_style;
		logic [31:0] c [7];
		logic [2:0]  n;

		sb            = new();
		arst_n        = 1'b0;
		in_if.valid   = 1'b0;
		in_if.sample_in = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = '0;
		cfg_if.data   = '0;
		samples_sent  = 0;
		reg_writes    = 0;
		settings_used = 1;
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset state: all coefficients zero, so the output is zero.
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		drain_filter();

		// Tap count zero acts as a pure gain stage; spare indexes are ignored.
		load_filter(Q_ONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 3'd0);
		write_reg(REG_SPARE_LO, Q_MAX);
		write_reg(REG_SPARE_HI, Q_MIN);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		send_sample('1);
		send_sample('0);
		drain_filter();

		// Corner coefficients, including the most negative feedback value,
		// with a tap count above the maximum.
		in_gaps_on    = 1'b0;
		out_stalls_on = 1'b0;
		load_filter(Q_MIN, Q_MAX, '1, Q_ONE, Q_MIN, Q_MAX, 32'h8000_0001, 3'd7);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		send_sample(Q_ONE);
		send_sample('1);
		send_sample(32'h0000_0001);
		send_sample(Q_NEG1);
		send_sample(Q_MAX);
		send_sample('0);
		drain_filter();

		// Shrinking the tap count must leave the upper delay entries alone,
		// and growing it again must pick them back up.
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
		write_reg(REG_TAPS, 32'd2);
		send_sample(Q_ONE);
		send_sample(Q_MIN);
		send_sample(32'h1234_5678);
		drain_filter();
		write_reg(REG_TAPS, 32'd4);
		send_sample(Q_MAX);
		send_sample(32'hEDCB_A987);
		send_sample('0);
		drain_filter();
		settings_used += 2;

		for (int unsigned p = 0; p < RAND_PHASES; p++) begin
			coef_style   = $urandom_range(0, 2);
			sample_style = $urandom_range(0, 2);
			for (int k = 0; k < 7; k++) begin
				c[k] = pick_coef(coef_style);
			end
			if (p == 1) begin
				for (int k = 0; k < 7; k++) c[k] = Q_MAX;
			end else if (p == 2) begin
				for (int k = 0; k < 7; k++) c[k] = Q_MIN;
			end
			n = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
			                                : 3'($urandom_range(1, 4));
			if (p == 3) begin
				n = 3'd1;
			end else if (p == 4) begin
				n = 3'd4;
			end
			load_filter(c[0], c[1], c[2], c[3], c[4], c[5], c[6], n);
			in_gaps_on    = ($urandom_range(0, 2) != 0);
			out_stalls_on = ($urandom_range(0, 2) != 0);
			for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
				send_sample(pick_sample(sample_style));
			end
			drain_filter();
		end

		$display("Covered %0d samples over %0d filter settings, %0d register writes.",
		         samples_sent, settings_used, reg_writes);
		$display("Compared %0d outputs, %0d mismatches.", sb.compared, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d outputs never arrived", sb.pending_outputs.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/iirq24_pkg.sv
src/iirq24_ifs.sv
src/iirq24_mult.sv
src/iirq24_seq.sv
src/iir_direct_form2_q24_core.sv
sim/tb_iir_direct_form2_q24_core.sv
